// ----- rtl/crps_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package crps_pkg;

    localparam int MAX_POINTS = 64;
    localparam int DIMS       = 3;

    localparam int COORD_W    = 16;
    localparam int CMD_W      = 2;
    localparam int RANK_W     = 6;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 7;
    localparam int RADIUS_W   = 34;
    localparam int SQ_W       = 2 * COORD_W;
    localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    // valid map is scanned eight bits a cycle when looking up a rank
    localparam int GROUP_SZ   = 8;
    localparam int N_GROUPS   = (MAX_POINTS + GROUP_SZ - 1) / GROUP_SZ;
    localparam int GRP_W      = (N_GROUPS > 1) ? $clog2(N_GROUPS) : 1;
    localparam int VPAD_W     = N_GROUPS * GROUP_SZ;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PICK  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANK  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } t_point;

    typedef struct packed {
        logic             valid;
        logic             hit;
        logic [IDX_W-1:0] idx;
    } t_hit;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        t_point              sample;
        logic [COUNT_W-1:0]  removed;
        logic [COUNT_W-1:0]  remaining;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/crps_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface crps_in_if;
    import crps_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          command;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic [RANK_W-1:0]         pick_rank;

    modport source (output valid, command, coord_x, coord_y, coord_z, pick_rank,
                    input ready);
    modport sink   (input valid, command, coord_x, coord_y, coord_z, pick_rank,
                    output ready);
endinterface

interface crps_out_if;
    import crps_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status;
    logic signed [COORD_W-1:0] sample_x;
    logic signed [COORD_W-1:0] sample_y;
    logic signed [COORD_W-1:0] sample_z;
    logic [COUNT_W-1:0]        removed_count;
    logic [COUNT_W-1:0]        remaining_count;

    modport source (output valid, status, sample_x, sample_y, sample_z,
                    removed_count, remaining_count, input ready);
    modport sink   (input valid, status, sample_x, sample_y, sample_z,
                    removed_count, remaining_count, output ready);
endinterface

`default_nettype wire

// ----- rtl/covering_radius_point_sampler.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Greedy covering-radius sampler over a store of up to MAX_POINTS 3-D Q8.8
// points. Every input word gives exactly one result word. Loads, clears,
// unused commands and rejected picks go straight to the result state. A
// successful pick is accepted, locates the ranked point (the valid map is
// walked eight entries a cycle), fetches it, sweeps the point RAM through its
// single read port, one entry per cycle, then drains the distance pipeline and
// writes the result. A new word is taken only once the previous result has
// moved to the output register. The radius register may be written only while
// the block is idle; distances are exact.
module covering_radius_point_sampler (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    crps_in_if.sink                            i_in,
    crps_out_if.source                         o_out,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [crps_pkg::RADIUS_W-1:0] i_cfg_wr_data
);
    import crps_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_RDSAMP = 3'd2;
    localparam logic [2:0] S_SAMP   = 3'd3;
    localparam logic [2:0] S_SWEEP  = 3'd4;
    localparam logic [2:0] S_DRAIN  = 3'd5;
    localparam logic [2:0] S_RESULT = 3'd6;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_POINTS - 1);

    logic [2:0]            r_state;
    logic [MAX_POINTS-1:0] r_valid;
    logic [COUNT_W-1:0]    r_fill;
    logic [COUNT_W-1:0]    r_live;
    logic [COUNT_W-1:0]    r_removed;
    logic [RADIUS_W-1:0]   r_radius;
    logic [RANK_W-1:0]     r_rank;
    logic [GRP_W-1:0]      r_group;
    logic [COUNT_W-1:0]    r_seen;
    logic [IDX_W-1:0]      r_chosen;
    logic [IDX_W-1:0]      r_addr;
    logic                  r_tag_v;
    logic [IDX_W-1:0]      r_tag_idx;
    t_point                r_sample;
    t_result               r_res;
    t_result               r_out;
    logic                  r_out_v;

    logic                  accept;
    logic                  out_free;
    t_point                wr_point;
    t_point                rd_data;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic                  ram_we;
    t_hit                  hit;
    logic                  dist_busy;

    logic [VPAD_W-1:0]     valid_pad;
    logic [GROUP_SZ-1:0]   grp_bits;
    logic [COUNT_W-1:0]    n_seen;
    logic                  scan_found;
    logic [2:0]            scan_j;

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign out_free   = !r_out_v || o_out.ready;

    assign wr_point.x = i_in.coord_x;
    assign wr_point.y = i_in.coord_y;
    assign wr_point.z = i_in.coord_z;
    assign ram_we     = accept && (i_in.command == CMD_LOAD)
                        && (r_fill < COUNT_W'(MAX_POINTS));

    assign rd_en   = (r_state == S_RDSAMP) || (r_state == S_SWEEP);
    assign rd_addr = (r_state == S_RDSAMP) ? r_chosen : r_addr;

    crps_point_ram u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (r_fill[IDX_W-1:0]),
        .i_wr_data (wr_point),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    crps_dist_unit u_dist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_tag_v && r_valid[r_tag_idx]),
        .i_idx    (r_tag_idx),
        .i_point  (rd_data),
        .i_sample (r_sample),
        .i_radius (r_radius),
        .o_hit    (hit),
        .o_busy   (dist_busy)
    );

    // rank lookup: one group of eight valid bits per cycle
    assign valid_pad = VPAD_W'(r_valid);
    assign grp_bits  = valid_pad[r_group*GROUP_SZ +: GROUP_SZ];

    always_comb begin
        n_seen     = r_seen;
        scan_found = 1'b0;
        scan_j     = '0;
        for (int j = 0; j < GROUP_SZ; j++) begin
            if (grp_bits[j] && !scan_found) begin
                if (n_seen == COUNT_W'(r_rank)) begin
                    scan_found = 1'b1;
                    scan_j     = 3'(j);
                end else begin
                    n_seen = n_seen + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= '0;
        end else if (i_cfg_wr_en) begin
            r_radius <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_fill    <= '0;
            r_live    <= '0;
            r_removed <= '0;
            r_tag_v   <= 1'b0;
        end else begin
            r_tag_v <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_rank         <= i_in.pick_rank;
                        r_res.status   <= ST_OK;
                        r_res.sample   <= '0;
                        r_res.removed  <= '0;
                        r_res.remaining <= r_live;
                        r_state        <= S_RESULT;
                        case (i_in.command)
                            CMD_LOAD: begin
                                if (r_fill >= COUNT_W'(MAX_POINTS)) begin
                                    r_res.status <= ST_FULL;
                                end else begin
                                    r_valid[r_fill[IDX_W-1:0]] <= 1'b1;
                                    r_fill          <= r_fill + 1'b1;
                                    r_live          <= r_live + 1'b1;
                                    r_res.remaining <= r_live + 1'b1;
                                end
                            end
                            CMD_PICK: begin
                                if (r_live == '0) begin
                                    r_res.status <= ST_EMPTY;
                                end else if (COUNT_W'(i_in.pick_rank) >= r_live) begin
                                    r_res.status <= ST_RANK;
                                end else begin
                                    r_group   <= '0;
                                    r_seen    <= '0;
                                    r_removed <= '0;
                                    r_state   <= S_SCAN;
                                end
                            end
                            CMD_CLEAR: begin
                                r_valid         <= '0;
                                r_fill          <= '0;
                                r_live          <= '0;
                                r_res.remaining <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_SCAN: begin
                    r_seen <= n_seen;
                    if (scan_found) begin
                        r_chosen <= IDX_W'(int'(r_group) * GROUP_SZ + int'(scan_j));
                        r_state  <= S_RDSAMP;
                    end else begin
                        r_group <= r_group + 1'b1;
                    end
                end
                S_RDSAMP: begin
                    r_state <= S_SAMP;
                end
                S_SAMP: begin
                    r_sample <= rd_data;
                    r_addr   <= '0;
                    r_state  <= S_SWEEP;
                end
                S_SWEEP: begin
                    r_tag_v   <= 1'b1;
                    r_tag_idx <= r_addr;
                    if (r_addr == LAST_IDX) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_DRAIN: begin
                    // last hit has been counted once the pipeline is empty
                    if (!r_tag_v && !dist_busy) begin
                        r_live          <= r_live - r_removed;
                        r_res.status    <= ST_OK;
                        r_res.sample    <= r_sample;
                        r_res.removed   <= r_removed;
                        r_res.remaining <= r_live - r_removed;
                        r_state         <= S_RESULT;
                    end
                end
                S_RESULT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (hit.valid && hit.hit) begin
                r_valid[hit.idx] <= 1'b0;
                r_removed        <= r_removed + 1'b1;
            end
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if ((r_state == S_RESULT) && out_free) begin
            r_out_v <= 1'b1;
        end else if (o_out.ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_RESULT) && out_free) begin
            r_out <= r_res;
        end
    end

    assign o_out.valid           = r_out_v;
    assign o_out.status          = r_out.status;
    assign o_out.sample_x        = r_out.sample.x;
    assign o_out.sample_y        = r_out.sample.y;
    assign o_out.sample_z        = r_out.sample.z;
    assign o_out.removed_count   = r_out.removed;
    assign o_out.remaining_count = r_out.remaining;

endmodule

`default_nettype wire

// ----- rtl/crps_point_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module crps_point_ram (
    input  wire logic                   i_clk,
    input  wire logic                   i_wr_en,
    input  wire logic [crps_pkg::IDX_W-1:0] i_wr_addr,
    input  wire crps_pkg::t_point       i_wr_data,
    input  wire logic                   i_rd_en,
    input  wire logic [crps_pkg::IDX_W-1:0] i_rd_addr,
    output crps_pkg::t_point            o_rd_data
);
    import crps_pkg::*;

    t_point r_mem [MAX_POINTS];
    t_point r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- rtl/crps_dist_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// three stages: |diff|, squares, sum and compare
module crps_dist_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire logic [crps_pkg::IDX_W-1:0]  i_idx,
    input  wire crps_pkg::t_point            i_point,
    input  wire crps_pkg::t_point            i_sample,
    input  wire logic [crps_pkg::RADIUS_W-1:0] i_radius,
    output crps_pkg::t_hit                   o_hit,
    output logic                             o_busy
);
    import crps_pkg::*;

    function automatic logic [COORD_W-1:0] abs_diff(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [COORD_W:0] d;
        logic [COORD_W:0]        m;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        m = d[COORD_W] ? (COORD_W+1)'(-d) : d;
        return m[COORD_W-1:0];
    endfunction

    logic               r1_v, r2_v, r3_v;
    logic [IDX_W-1:0]   r1_idx, r2_idx, r3_idx;
    logic [COORD_W-1:0] r1_ax, r1_ay, r1_az;
    logic [SQ_W-1:0]    r2_sx, r2_sy, r2_sz;
    logic               r3_hit;
    logic [RADIUS_W-1:0] sum;

    assign sum = RADIUS_W'(r2_sx) + RADIUS_W'(r2_sy) + RADIUS_W'(r2_sz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_idx <= i_idx;
        r1_ax  <= abs_diff(i_point.x, i_sample.x);
        r1_ay  <= (DIMS > 1) ? abs_diff(i_point.y, i_sample.y) : '0;
        r1_az  <= (DIMS > 2) ? abs_diff(i_point.z, i_sample.z) : '0;

        r2_idx <= r1_idx;
        r2_sx  <= SQ_W'(r1_ax) * SQ_W'(r1_ax);
        r2_sy  <= SQ_W'(r1_ay) * SQ_W'(r1_ay);
        r2_sz  <= SQ_W'(r1_az) * SQ_W'(r1_az);

        r3_idx <= r2_idx;
        r3_hit <= (sum <= i_radius);
    end

    assign o_hit.valid = r3_v;
    assign o_hit.hit   = r3_hit;
    assign o_hit.idx   = r3_idx;
    assign o_busy      = r1_v | r2_v | r3_v;

endmodule

`default_nettype wire
